[design/spr_pkg.sv]
// Package for the stream pattern replace block: payload structs, queue job
// type, register indexes and fixed field widths. No dependencies.
package spr_pkg;

    localparam int PAT_BYTES  = 16;   // pattern bytes held by the registers
    localparam int REPL_BYTES = 32;   // replacement bytes held by the registers
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 4;
    localparam int PLEN_W     = 5;
    localparam int RLEN_W     = 6;
    localparam int Q_DEPTH    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LO   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HI   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPL_LEN = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPL_W0  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPL_W1  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REPL_W2  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_REPL_W3  = 4'd7;

    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] in_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } t_out_word;

    // one job from front to back: a single byte, or a whole replacement run
    typedef struct packed {
        logic       repl;
        logic       last;
        logic [7:0] data;
    } t_job;

    typedef struct packed {
        logic [8*PAT_BYTES-1:0]  pattern;
        logic [8*REPL_BYTES-1:0] repl;
        logic                    repl_none;   // effective replacement length is zero
    } t_cfg;

endpackage

[design/spr_cfg.sv]
// Configuration registers of the stream pattern replace block and the
// clamped pattern/replacement lengths. Depends on spr_pkg.
module spr_cfg import spr_pkg::*; #(
    parameter int PATTERN_MAX     = 16,
    parameter int REPLACEMENT_MAX = 32,
    parameter int CW              = $clog2(PATTERN_MAX + 1),
    parameter int RL_W            = $clog2(REPLACEMENT_MAX + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg,
    output logic [CW-1:0]         o_plen,
    output logic [RL_W-1:0]       o_rlen,
    output logic                  o_win_clr
);

    logic [PLEN_W-1:0]       r_plen;
    logic [RLEN_W-1:0]       r_rlen;
    logic [8*PAT_BYTES-1:0]  r_pat;
    logic [8*REPL_BYTES-1:0] r_repl;
    logic                    wr;

    assign o_cfg_ready = 1'b1;
    assign wr          = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= PLEN_W'(1);
            r_rlen <= '0;
            r_pat  <= '0;
            r_repl <= '0;
        end else if (wr) begin
            unique case (i_cfg_index)
                REG_PAT_LEN:  r_plen <= i_cfg_data[PLEN_W-1:0];
                REG_PAT_LO:   r_pat[63:0] <= i_cfg_data;
                REG_PAT_HI:   r_pat[127:64] <= i_cfg_data;
                REG_REPL_LEN: r_rlen <= i_cfg_data[RLEN_W-1:0];
                REG_REPL_W0:  r_repl[63:0] <= i_cfg_data;
                REG_REPL_W1:  r_repl[127:64] <= i_cfg_data;
                REG_REPL_W2:  r_repl[191:128] <= i_cfg_data;
                REG_REPL_W3:  r_repl[255:192] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a new pattern length drops whatever the window holds
    assign o_win_clr = wr && (i_cfg_index == REG_PAT_LEN);

    always_comb begin
        if (r_plen == '0) begin
            o_plen = CW'(1);
        end else if (int'(r_plen) > PATTERN_MAX) begin
            o_plen = CW'(PATTERN_MAX);
        end else begin
            o_plen = CW'(r_plen);
        end
        if (int'(r_rlen) > REPLACEMENT_MAX) begin
            o_rlen = RL_W'(REPLACEMENT_MAX);
        end else begin
            o_rlen = RL_W'(r_rlen);
        end
        o_cfg.pattern   = r_pat;
        o_cfg.repl      = r_repl;
        o_cfg.repl_none = (o_rlen == '0);
    end

endmodule

[design/spr_front.sv]
// Front part: holds the match window, compares it against the pattern and
// pushes byte / replacement jobs into the queue. Depends on spr_pkg.
module spr_front import spr_pkg::*; #(
    parameter int PATTERN_MAX = 16,
    parameter int CW          = $clog2(PATTERN_MAX + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  t_in_word        i_word,
    input  t_cfg            i_cfg,
    input  logic [CW-1:0]   i_plen,
    input  logic            i_win_clr,
    output logic            o_q_push,
    output t_job            o_q_job,
    input  logic            i_q_full
);

    logic [7:0]    r_win [PATTERN_MAX];
    logic [7:0]    n_win [PATTERN_MAX];
    logic [7:0]    ins   [PATTERN_MAX];
    logic [7:0]    pat_b [PATTERN_MAX];
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_flush, n_flush;
    logic [CW-1:0] cnt_inc;
    logic          accept;
    logic          win_full;
    logic          match;

    // pattern bytes past the register file read as zero
    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_pat
        if (g < PAT_BYTES) begin : g_reg
            assign pat_b[g] = i_cfg.pattern[8*g +: 8];
        end else begin : g_zero
            assign pat_b[g] = 8'h00;
        end
    end

    assign o_full = i_q_full || r_flush;
    assign accept = i_push && !o_full;

    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            ins[i] = (CW'(i) == r_cnt) ? i_word.in_byte : r_win[i];
        end
        match = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (i < int'(i_plen) && ins[i] != pat_b[i]) begin
                match = 1'b0;
            end
        end
        cnt_inc  = r_cnt + CW'(1);
        win_full = (cnt_inc == i_plen);

        n_win    = r_win;
        n_cnt    = r_cnt;
        n_flush  = r_flush;
        o_q_push = 1'b0;
        o_q_job  = '0;

        if (r_flush) begin
            // drain one byte a cycle from the head of the window while the queue has room
            if (!i_q_full) begin
                o_q_push     = 1'b1;
                o_q_job.data = r_win[0];
                o_q_job.last = (r_cnt == CW'(1));
                for (int i = 0; i < PATTERN_MAX - 1; i++) begin
                    n_win[i] = r_win[i+1];
                end
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_flush = 1'b0;
                end
            end
        end else if (accept) begin
            if (i_word.cmd == CMD_FLUSH) begin
                n_flush = (r_cnt != '0);
            end else begin
                n_win = ins;
                if (!win_full) begin
                    n_cnt = cnt_inc;
                end else if (match) begin
                    n_cnt        = '0;
                    o_q_push     = !i_cfg.repl_none;
                    o_q_job.repl = 1'b1;
                end else begin
                    o_q_push     = 1'b1;
                    o_q_job.data = ins[0];
                    o_q_job.last = 1'b1;
                    for (int i = 0; i < PATTERN_MAX - 1; i++) begin
                        n_win[i] = ins[i+1];
                    end
                    n_cnt = r_cnt;
                end
            end
        end

        if (i_win_clr) begin
            n_cnt   = '0;
            n_flush = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_flush <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_flush <= n_flush;
        end
    end

    a_cnt_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < i_plen)
        else $error("window count reached pattern length");

    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> r_cnt != '0)
        else $error("flush drain with empty window");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> !i_q_full)
        else $error("job pushed into full queue");

endmodule

[design/spr_queue.sv]
// Short job queue between front and back; count-based full/empty flags.
// Depends on spr_pkg.
module spr_queue import spr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    localparam int PW = $clog2(Q_DEPTH);
    localparam int NW = $clog2(Q_DEPTH + 1);

    t_job          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [NW-1:0] r_cnt;

    assign o_full  = (r_cnt == NW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            r_cnt <= r_cnt + NW'(i_push) - NW'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue underflow");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NW'(Q_DEPTH))
        else $error("queue count out of range");

endmodule

[design/spr_back.sv]
// Back part: pops jobs, expands replacement runs one byte a cycle while the
// output register is free, which holds the result word. Depends on spr_pkg.
module spr_back import spr_pkg::*; #(
    parameter int REPLACEMENT_MAX = 32,
    parameter int RL_W            = $clog2(REPLACEMENT_MAX + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cfg            i_cfg,
    input  logic [RL_W-1:0] i_rlen,
    input  t_job            i_q_job,
    input  logic            i_q_empty,
    output logic            o_q_pop,
    output logic            o_empty,
    input  logic            i_pop,
    output t_out_word       o_word
);

    logic            r_busy, n_busy;
    logic [RL_W-1:0] r_ridx, n_ridx;
    logic            r_out_valid, n_out_valid;
    t_out_word       r_out, n_out;
    logic            out_free;
    logic [RL_W-1:0] cur_idx;
    logic [4:0]      sel;
    logic [7:0]      repl_byte;
    logic            run_end;

    assign out_free = !r_out_valid || (i_pop && r_out_valid);
    assign o_q_pop  = !r_busy && !i_q_empty && out_free;
    assign o_empty  = !r_out_valid;
    assign o_word   = r_out;

    always_comb begin
        cur_idx   = r_busy ? r_ridx : '0;
        sel       = 5'(cur_idx);
        repl_byte = (int'(cur_idx) < REPL_BYTES) ? i_cfg.repl[{sel, 3'b000} +: 8] : 8'h00;
        run_end   = (cur_idx == i_rlen - RL_W'(1));

        n_busy      = r_busy;
        n_ridx      = r_ridx;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_pop;

        if (r_busy && out_free) begin
            n_out.out_byte = repl_byte;
            n_out.run_last = run_end;
            n_out_valid    = 1'b1;
            n_ridx         = r_ridx + RL_W'(1);
            n_busy         = !run_end;
        end else if (o_q_pop) begin
            n_out_valid = 1'b1;
            if (i_q_job.repl) begin
                n_out.out_byte = repl_byte;
                n_out.run_last = run_end;
                n_ridx         = RL_W'(1);
                n_busy         = !run_end;
            end else begin
                n_out.out_byte = i_q_job.data;
                n_out.run_last = i_q_job.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_ridx <= n_ridx;
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    a_busy_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_out_valid)
        else $error("replacement run without pending word");

    a_busy_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_ridx != '0)
        else $error("run index restarted while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_pop |=> r_out_valid && $stable(r_out))
        else $error("waiting result word changed");

endmodule

[design/stream_pattern_replace.sv]
// Streaming find-and-replace. One byte accepted per cycle when not full;
// results pass the job queue, then the output register. The back stage
// emits a replacement run one byte per cycle while the output is free; the
// front still takes input until the 4-entry job queue fills. A flush drains
// the window one byte per cycle while the queue has room, full held high.
// Synchronous active-low reset clears window count, queue and output valid.
module stream_pattern_replace import spr_pkg::*; #(
    parameter int PATTERN_MAX     = 16,
    parameter int REPLACEMENT_MAX = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_in_word              i_in_word,
    output logic                  empty,
    input  logic                  pop,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW   = $clog2(PATTERN_MAX + 1);
    localparam int RL_W = $clog2(REPLACEMENT_MAX + 1);

    t_cfg            cfg;
    logic [CW-1:0]   plen;
    logic [RL_W-1:0] rlen;
    logic            win_clr;
    logic            q_push, q_full, q_pop, q_empty;
    t_job            q_in, q_out;

    spr_cfg #(
        .PATTERN_MAX     (PATTERN_MAX),
        .REPLACEMENT_MAX (REPLACEMENT_MAX),
        .CW              (CW),
        .RL_W            (RL_W)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_plen      (plen),
        .o_rlen      (rlen),
        .o_win_clr   (win_clr)
    );

    spr_front #(
        .PATTERN_MAX (PATTERN_MAX),
        .CW          (CW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_word    (i_in_word),
        .i_cfg     (cfg),
        .i_plen    (plen),
        .i_win_clr (win_clr),
        .o_q_push  (q_push),
        .o_q_job   (q_in),
        .i_q_full  (q_full)
    );

    spr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_out),
        .o_empty (q_empty)
    );

    spr_back #(
        .REPLACEMENT_MAX (REPLACEMENT_MAX),
        .RL_W            (RL_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_rlen    (rlen),
        .i_q_job   (q_out),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_word    (o_out_word)
    );

endmodule

[test/stream_pattern_replace_tb.sv]
// Self-checking testbench for stream_pattern_replace: directed cases, then random
// settings and byte streams, checked word by word by a scoreboard class.
// Depends on spr_pkg (design/spr_pkg.sv) and the stream_pattern_replace RTL.
module stream_pattern_replace_tb import spr_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 4000;   // cycles with no handshake before giving up
    localparam int SETTLE_WAIT  = 12;     // cycles to let in-flight work finish
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_WORDS  = 36;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd11;   // not decoded by the block

    // Scoreboard: own copy of registers and window, expected output words.
    class replace_scoreboard;
        logic [PLEN_W-1:0] pat_len_reg;
        logic [63:0]       pat_lo;
        logic [63:0]       pat_hi;
        logic [RLEN_W-1:0] repl_len_reg;
        logic [63:0]       repl_w [4];
        logic [7:0]        window [PAT_BYTES];
        int                win_count;
        t_out_word         expected_words [$];
        int                errors;
        int                inputs_seen;
        int                results_seen;
        int                match_count;

        function new();
            pat_len_reg  = 5'd1;
            pat_lo       = '0;
            pat_hi       = '0;
            repl_len_reg = '0;
            foreach (repl_w[i]) repl_w[i] = '0;
            foreach (window[i]) window[i] = '0;
            win_count    = 0;
            errors       = 0;
            inputs_seen  = 0;
            results_seen = 0;
            match_count  = 0;
        endfunction

        function int pat_len_eff();
            int n;
            n = int'(pat_len_reg);
            if (n == 0) n = 1;
            if (n > PAT_BYTES) n = PAT_BYTES;
            return n;
        endfunction

        function logic [7:0] pat_byte(int i);
            if (i < 8) return pat_lo[8*i +: 8];
            return pat_hi[8*(i-8) +: 8];
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] d);
            case (idx)
                REG_PAT_LEN: begin
                    pat_len_reg = d[PLEN_W-1:0];
                    win_count   = 0;   // a new length drops the window
                end
                REG_PAT_LO:   pat_lo = d;
                REG_PAT_HI:   pat_hi = d;
                REG_REPL_LEN: repl_len_reg = d[RLEN_W-1:0];
                REG_REPL_W0:  repl_w[0] = d;
                REG_REPL_W1:  repl_w[1] = d;
                REG_REPL_W2:  repl_w[2] = d;
                REG_REPL_W3:  repl_w[3] = d;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void note_input(t_in_word w);
            logic [7:0] run [$];
            t_out_word  o;
            int         len;
            int         rl;
            bit         hit;
            len = pat_len_eff();
            inputs_seen++;
            if (w.cmd == CMD_FLUSH) begin
                for (int i = 0; i < win_count; i++) run.push_back(window[i]);
                win_count = 0;
            end else begin
                window[win_count] = w.in_byte;
                win_count++;
                if (win_count == len) begin
                    hit = 1'b1;
                    for (int i = 0; i < len; i++)
                        if (window[i] != pat_byte(i)) hit = 1'b0;
                    if (hit) begin
                        match_count++;
                        rl = int'(repl_len_reg);
                        if (rl > REPL_BYTES) rl = REPL_BYTES;
                        for (int i = 0; i < rl; i++)
                            run.push_back(repl_w[i/8][8*(i%8) +: 8]);
                        win_count = 0;
                    end else begin
                        run.push_back(window[0]);
                        for (int i = 0; i < len - 1; i++) window[i] = window[i+1];
                        win_count--;
                    end
                end
            end
            foreach (run[i]) begin
                o.out_byte = run[i];
                o.run_last = (i == run.size() - 1);
                expected_words.push_back(o);
            end
        endfunction

        function void check_result(t_out_word got);
            t_out_word exp_w;
            results_seen++;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word out_byte=%h run_last=%0b",
                         $realtime, got.out_byte, got.run_last);
                errors++;
                return;
            end
            exp_w = expected_words.pop_front();
            if (got.out_byte !== exp_w.out_byte) begin
                $display("%0t: out_byte mismatch expected %h actual %h",
                         $realtime, exp_w.out_byte, got.out_byte);
                errors++;
            end
            if (got.run_last !== exp_w.run_last) begin
                $display("%0t: run_last mismatch expected %0b actual %0b",
                         $realtime, exp_w.run_last, got.run_last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    t_in_word              in_word = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    t_out_word             out_word;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int send_idle = 0;
    int stall_pct = 0;
    int settings_used = 0;

    replace_scoreboard sb = new();

    stream_pattern_replace u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_word   (in_word),
        .empty       (empty),
        .pop         (pop),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // receiver side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    // monitor: results first, then accepted words and register writes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) sb.check_result(out_word);
            if (push && !full) sb.note_input(in_word);
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
        $display("** stream_pattern_replace: FAILED **");
        $finish;
    end

    task automatic send_word(input logic cmd, input logic [7:0] b);
        t_in_word w;
        w.cmd     = cmd;
        w.in_byte = b;
        while ($urandom_range(99, 0) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push    <= 1'b1;
        in_word <= w;
        do @(posedge i_clk); while (full);
    endtask

    // leaves valid high; caller drops it after the last write of a batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge i_clk); while (!cfg_ready);
    endtask

    task automatic cfg_done();
        cfg_valid <= 1'b0;
        settings_used++;
        @(posedge i_clk);
    endtask

    // wait until every expected word is out and the block has gone quiet
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_replacement(input logic [5:0] rlen);
        write_reg(REG_REPL_LEN, {58'd0, rlen});
        write_reg(REG_REPL_W0, {$urandom, $urandom});
        write_reg(REG_REPL_W1, {$urandom, $urandom});
        write_reg(REG_REPL_W2, {$urandom, $urandom});
        write_reg(REG_REPL_W3, {$urandom, $urandom});
    endtask

    task automatic directed_part();
        // zero length acts as one; match, extreme bytes, flush of empty window
        write_reg(REG_PAT_LEN, 64'd0);
        write_reg(REG_PAT_LO, 64'h41);
        write_reg(REG_PAT_HI, 64'hFFFF_FFFF_FFFF_FFFF);
        write_replacement(6'd3);
        write_reg(REG_SPARE, 64'hDEAD_BEEF_0000_FFFF);
        cfg_done();
        send_word(CMD_DATA, 8'h41);
        send_word(CMD_DATA, 8'h00);
        send_word(CMD_DATA, 8'hFF);
        send_word(CMD_FLUSH, 8'hFF);
        settle();

        // pattern AAB with empty replacement: third A breaks, then restarts a match
        write_reg(REG_PAT_LEN, 64'd3);
        write_reg(REG_PAT_LO, 64'h42_41_41);
        write_reg(REG_REPL_LEN, 64'd0);
        cfg_done();
        send_word(CMD_DATA, 8'h41);
        send_word(CMD_DATA, 8'h41);
        send_word(CMD_DATA, 8'h41);
        send_word(CMD_DATA, 8'h42);
        send_word(CMD_DATA, 8'h41);
        send_word(CMD_DATA, 8'h41);
        send_word(CMD_FLUSH, 8'h00);
        settle();

        // pattern bytes rewritten with a byte in the window; overlong replacement
        send_word(CMD_DATA, 8'h58);
        settle();
        write_reg(REG_PAT_LO, 64'h5A_59_58);
        write_reg(REG_REPL_LEN, 64'd63);
        cfg_done();
        send_word(CMD_DATA, 8'h59);
        send_word(CMD_DATA, 8'h5A);
        settle();

        // length rewritten over a partial match drops it; overlong length
        send_word(CMD_DATA, 8'h58);
        send_word(CMD_DATA, 8'h59);
        settle();
        write_reg(REG_PAT_LEN, 64'd31);
        write_reg(REG_PAT_HI, {$urandom, $urandom});
        cfg_done();
        send_word(CMD_DATA, 8'h11);
        send_word(CMD_FLUSH, 8'h80);
        settle();
    endtask

    task automatic random_phase(input int n_items);
        int unsigned r;
        int          sent;
        int          len;
        int          cut;
        logic [4:0]  plen;
        logic [5:0]  rlen;
        r = $urandom_range(99, 0);
        if (r < 8)       plen = 5'd0;
        else if (r < 16) plen = 5'd16;
        else if (r < 24) plen = 5'($urandom_range(31, 17));
        else             plen = 5'($urandom_range(6, 1));
        r = $urandom_range(99, 0);
        if (r < 10)      rlen = 6'($urandom_range(63, 33));
        else if (r < 20) rlen = 6'd0;
        else if (r < 30) rlen = 6'd32;
        else             rlen = 6'($urandom_range(8, 1));
        // sometimes keep the length so the window carries over new pattern bytes
        if ($urandom_range(99, 0) < 75) write_reg(REG_PAT_LEN, {59'd0, plen});
        write_reg(REG_PAT_LO, {$urandom, $urandom});
        write_reg(REG_PAT_HI, {$urandom, $urandom});
        write_replacement(rlen);
        cfg_done();

        len  = sb.pat_len_eff();
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99, 0);
            if (r < 55) begin
                for (int i = 0; i < len; i++) send_word(CMD_DATA, sb.pat_byte(i));
                sent += len;
            end else if (r < 70) begin
                cut = (len > 1) ? $urandom_range(len - 1, 1) : 0;
                for (int i = 0; i < cut; i++) send_word(CMD_DATA, sb.pat_byte(i));
                send_word(CMD_DATA, 8'($urandom));
                sent += cut + 1;
            end else if (r < 92) begin
                if ($urandom_range(1, 0))
                    send_word(CMD_DATA, sb.pat_byte($urandom_range(len - 1, 0)));
                else
                    send_word(CMD_DATA, 8'($urandom));
                sent++;
            end else begin
                send_word(CMD_FLUSH, 8'($urandom));
                sent++;
            end
        end
        if ($urandom_range(1, 0)) send_word(CMD_FLUSH, 8'($urandom));
        settle();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_part();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 4)
                0: begin send_idle = 0;  stall_pct = 0;  end
                1: begin send_idle = 48; stall_pct = 0;  end
                2: begin send_idle = 0;  stall_pct = 48; end
                default: begin send_idle = 14; stall_pct = 14; end
            endcase
            random_phase(PHASE_WORDS);
        end

        settle();
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected words never arrived", $realtime, sb.pending());
            sb.errors++;
        end
        $display("covered %0d input words and %0d output words, %0d pattern matches,",
                 sb.inputs_seen, sb.results_seen, sb.match_count);
        $display("over %0d register settings with mixed idle and stall rates",
                 settings_used);
        if (sb.errors == 0) begin
            $display("** stream_pattern_replace: PASSED **");
        end else begin
            $display("** stream_pattern_replace: FAILED **");
        end
        $finish;
    end

endmodule

[stream_pattern_replace.f]
design/spr_pkg.sv
design/spr_cfg.sv
design/spr_front.sv
design/spr_queue.sv
design/spr_back.sv
design/stream_pattern_replace.sv
test/stream_pattern_replace_tb.sv
